// ===== rtl/core/btp_pkg.sv =====
// Shared types and constants for the binary thinning pass unit.
// Depends on nothing; imported by the row cells, the rule logic and the top level.

package btp_pkg;

   // Configuration port
   localparam int CSR_DATA_W = 11;
   typedef logic [2:0] csr_index_type;

   localparam csr_index_type CSR_ALGORITHM    = 3'd0;
   localparam csr_index_type CSR_SUBITERATION = 3'd1;
   localparam csr_index_type CSR_WIDTH        = 3'd2;
   localparam csr_index_type CSR_HEIGHT       = 3'd3;

   // Rule selection
   localparam logic ALG_ZHANG_SUEN = 1'b0;
   localparam logic ALG_GUO_HALL   = 1'b1;

   // 8-neighbourhood, clockwise from north
   typedef logic [7:0] nbr_type;

   localparam int NB_N  = 0;
   localparam int NB_NE = 1;
   localparam int NB_E  = 2;
   localparam int NB_SE = 3;
   localparam int NB_S  = 4;
   localparam int NB_SW = 5;
   localparam int NB_W  = 6;
   localparam int NB_NW = 7;

   // Taps of one window row: 0 is the newest pixel of that row
   typedef logic [2:0] row_taps_type;

endpackage

// ===== rtl/core/btp_line_mem.sv =====
// Circular pixel history memory: one write port, two registered read ports.
// Depends on nothing; instantiated by binary_thinning_pass_unit.

module btp_line_mem #(
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic              wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic              rd_data_a,
   output logic              rd_data_b
);

   localparam int DEPTH = 2 ** ADDR_W;

   logic hist_mem [DEPTH];
   logic rd_a_ff;
   logic rd_b_ff;

   // write side
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
   end

   // both read ports, read every cycle
   always_ff @(posedge clock) begin
      rd_a_ff <= hist_mem[rd_addr_a];
      rd_b_ff <= hist_mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/core/btp_row_cell.sv =====
// One window row cell: takes the row's newest pixel and shifts it through
// two taps on every accepted beat. Depends on btp_pkg.

module btp_row_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  logic                  head,
   output btp_pkg::row_taps_type taps
);

   import btp_pkg::*;

   logic d1_ff;
   logic d1_in;
   logic d2_ff;
   logic d2_in;

   // shift towards the older taps
   always_comb begin
      d1_in = d1_ff;
      d2_in = d2_ff;
      if (shift_en) begin
         d1_in = head;
         d2_in = d1_ff;
      end
   end

   // history before reset reads as background
   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= 1'b0;
         d2_ff <= 1'b0;
      end else begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
      end
   end

   assign taps = {d2_ff, d1_ff, head};

endmodule

// ===== rtl/core/btp_rule.sv =====
// Deletion test for the window centre: Zhang-Suen or Guo-Hall, either
// sub-iteration. Depends on btp_pkg.

module btp_rule (
   input  btp_pkg::nbr_type nbr,
   input  logic             algorithm,
   input  logic             subiteration,
   output logic             mark
);

   import btp_pkg::*;

   logic [3:0] zs_trans;
   logic [3:0] zs_count;
   logic       zs_m1;
   logic       zs_m2;
   logic       zs_mark;
   logic       p2, p3, p4, p5, p6, p7, p8, p9;
   logic [2:0] gh_c;
   logic [2:0] gh_n1;
   logic [2:0] gh_n2;
   logic [2:0] gh_nmin;
   logic       gh_m;
   logic       gh_mark;

   // Zhang-Suen: one 0->1 transition round the ring, 2..6 neighbours set
   always_comb begin
      zs_trans = '0;
      zs_count = '0;
      for (int k = 0; k < 8; k++) begin
         zs_trans = zs_trans + 4'((!nbr[k]) && nbr[(k + 1) % 8]);
         zs_count = zs_count + 4'(nbr[k]);
      end
      if (subiteration == 1'b0) begin
         zs_m1 = nbr[NB_N] & nbr[NB_E] & nbr[NB_S];
         zs_m2 = nbr[NB_E] & nbr[NB_S] & nbr[NB_W];
      end else begin
         zs_m1 = nbr[NB_N] & nbr[NB_E] & nbr[NB_W];
         zs_m2 = nbr[NB_N] & nbr[NB_S] & nbr[NB_W];
      end
      zs_mark = (zs_trans == 4'd1) && (zs_count >= 4'd2) && (zs_count <= 4'd6)
                && !zs_m1 && !zs_m2;
   end

   // Guo-Hall: connectivity number, pair counts and the directional term
   always_comb begin
      p2 = nbr[NB_N];
      p3 = nbr[NB_NE];
      p4 = nbr[NB_E];
      p5 = nbr[NB_SE];
      p6 = nbr[NB_S];
      p7 = nbr[NB_SW];
      p8 = nbr[NB_W];
      p9 = nbr[NB_NW];
      gh_c  = 3'(!p2 & (p3 | p4)) + 3'(!p4 & (p5 | p6))
            + 3'(!p6 & (p7 | p8)) + 3'(!p8 & (p9 | p2));
      gh_n1 = 3'(p9 | p2) + 3'(p3 | p4) + 3'(p5 | p6) + 3'(p7 | p8);
      gh_n2 = 3'(p2 | p3) + 3'(p4 | p5) + 3'(p6 | p7) + 3'(p8 | p9);
      gh_nmin = (gh_n1 < gh_n2) ? gh_n1 : gh_n2;
      if (subiteration == 1'b0) begin
         gh_m = (p6 | p7 | !p9) & p8;
      end else begin
         gh_m = (p2 | p3 | !p5) & p4;
      end
      gh_mark = (gh_c == 3'd1) && (gh_nmin >= 3'd2) && (gh_nmin <= 3'd3) && !gh_m;
   end

   assign mark = (algorithm == ALG_GUO_HALL) ? gh_mark : zs_mark;

endmodule

// ===== rtl/core/binary_thinning_pass_unit.sv =====
// Each accepted beat's result is registered into the output buffer; the first W beats of a frame give none.
// Throughput: one pixel per cycle while the output buffer has room, set by the 3x3 window and combinational rule logic.
// Results sit in a two-entry output buffer, so input is taken while one result waits.
// Reset (synchronous, active high) clears control, counters, valid flags and window taps to defaults;
// the history memory is not cleared: a fill count makes unwritten history read as zero.
// Depends on btp_pkg, btp_line_mem, btp_row_cell and btp_rule.

module binary_thinning_pass_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   // pixel input
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_pixel_in,
   // result output
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_pixel_out,
   output logic                            rsp_removed,
   output logic                            rsp_frame_last,
   output logic                            rsp_frame_changed,
   // configuration writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  btp_pkg::csr_index_type          csr_index,
   input  logic [btp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import btp_pkg::*;

   localparam int WW      = $clog2(MAX_WIDTH + 1);
   localparam int HW      = $clog2(MAX_HEIGHT + 1);
   localparam int HIST_AW = $clog2(2 * MAX_WIDTH + 3);
   localparam int FILL_W  = $clog2(2 * MAX_WIDTH + 1);
   localparam int CMP_W   = WW + 2;
   localparam int CW_W    = (WW > CSR_DATA_W) ? WW : CSR_DATA_W;
   localparam int CW_H    = (HW > CSR_DATA_W) ? HW : CSR_DATA_W;
   localparam int W_RESET = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
   localparam int H_RESET = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;
   localparam int FILL_MAX = 2 * MAX_WIDTH;

   typedef struct packed {
      logic pixel_out;
      logic removed;
      logic frame_last;
      logic frame_changed;
   } rsp_type;

   // configuration
   logic               algorithm_ff, algorithm_in;
   logic               subiter_ff, subiter_in;
   logic [WW-1:0]      width_ff, width_in;
   logic [HW-1:0]      height_ff, height_in;
   logic               csr_fire;
   logic               restart;
   logic [CW_W-1:0]    wd_w_ext;
   logic [CW_H-1:0]    wd_h_ext;
   logic [WW-1:0]      width_clamped;
   logic [HW-1:0]      height_clamped;

   // history addressing
   logic [HIST_AW-1:0] wp_ff, wp_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               valid_a_ff, valid_a_in;
   logic               valid_b_ff, valid_b_in;
   logic [HIST_AW-1:0] rd_addr_a;
   logic [HIST_AW-1:0] rd_addr_b;
   logic               mem_a;
   logic               mem_b;

   // window
   logic [2:0]         row_head;
   row_taps_type       row_taps [3];
   nbr_type            nbr;
   logic               centre;
   logic               mark;

   // frame position
   logic [WW-1:0]      warm_ff, warm_in;
   logic [HW-1:0]      row_ff, row_in;
   logic [WW-1:0]      col_ff, col_in;
   logic               any_ff, any_in;
   logic               accept;
   logic               produce;
   logic               interior;
   logic               rem;
   logic               last;
   logic               col_end;
   rsp_type            result;

   // output buffer
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;
   logic               skid_valid_ff, skid_valid_in;
   rsp_type            skid_ff, skid_in;
   logic               pop;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;

   // clamp written geometry into the supported range
   always_comb begin
      wd_w_ext = CW_W'(csr_wdata);
      wd_h_ext = CW_H'(csr_wdata);
      if (wd_w_ext < CW_W'(3)) begin
         width_clamped = WW'(3);
      end else if (wd_w_ext > CW_W'(MAX_WIDTH)) begin
         width_clamped = WW'(MAX_WIDTH);
      end else begin
         width_clamped = WW'(wd_w_ext);
      end
      if (wd_h_ext < CW_H'(3)) begin
         height_clamped = HW'(3);
      end else if (wd_h_ext > CW_H'(MAX_HEIGHT)) begin
         height_clamped = HW'(MAX_HEIGHT);
      end else begin
         height_clamped = HW'(wd_h_ext);
      end
   end

   // register writes
   always_comb begin
      algorithm_in = algorithm_ff;
      subiter_in   = subiter_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      restart      = 1'b0;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_ALGORITHM:    algorithm_in = csr_wdata[0];
            CSR_SUBITERATION: subiter_in   = csr_wdata[0];
            CSR_WIDTH: begin
               width_in = width_clamped;
               restart  = 1'b1;
            end
            CSR_HEIGHT: begin
               height_in = height_clamped;
               restart   = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // history write pointer, fill count and read addresses for the next beat
   always_comb begin
      wp_in   = accept ? wp_ff + HIST_AW'(1) : wp_ff;
      fill_in = fill_ff;
      if (accept && (fill_ff != FILL_W'(FILL_MAX))) begin
         fill_in = fill_ff + FILL_W'(1);
      end
      valid_a_in = CMP_W'(fill_in) >= CMP_W'(width_in);
      valid_b_in = CMP_W'(fill_in) >= CMP_W'({width_in, 1'b0});
      rd_addr_a  = wp_in - HIST_AW'(width_in);
      rd_addr_b  = wp_in - HIST_AW'({width_in, 1'b0});
   end

   btp_line_mem #(
      .ADDR_W (HIST_AW)
   ) u_line_mem (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (wp_ff),
      .wr_data   (req_pixel_in),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (mem_a),
      .rd_data_b (mem_b)
   );

   // three window rows: newest, one line back, two lines back
   assign row_head[0] = req_pixel_in;
   assign row_head[1] = mem_a & valid_a_ff;
   assign row_head[2] = mem_b & valid_b_ff;

   for (genvar r = 0; r < 3; r++) begin : g_row
      btp_row_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (accept),
         .head     (row_head[r]),
         .taps     (row_taps[r])
      );
   end

   // neighbourhood around the centre tap
   always_comb begin
      nbr        = '0;
      nbr[NB_N]  = row_taps[2][1];
      nbr[NB_NE] = row_taps[2][0];
      nbr[NB_E]  = row_taps[1][0];
      nbr[NB_SE] = row_taps[0][0];
      nbr[NB_S]  = row_taps[0][1];
      nbr[NB_SW] = row_taps[0][2];
      nbr[NB_W]  = row_taps[1][2];
      nbr[NB_NW] = row_taps[2][2];
      centre     = row_taps[1][1];
   end

   btp_rule u_rule (
      .nbr          (nbr),
      .algorithm    (algorithm_ff),
      .subiteration (subiter_ff),
      .mark         (mark)
   );

   // result for this beat and frame position update
   always_comb begin
      produce  = accept && (warm_ff >= width_ff);
      interior = (row_ff != '0) && ((row_ff + HW'(1)) < height_ff)
                 && (col_ff != '0) && ((col_ff + WW'(1)) < width_ff);
      rem      = centre & mark & interior;
      col_end  = (col_ff + WW'(1)) >= width_ff;
      last     = ((row_ff + HW'(1)) >= height_ff) && col_end;

      result.pixel_out     = centre & !rem;
      result.removed       = rem;
      result.frame_last    = last;
      result.frame_changed = last & (any_ff | rem);

      warm_in = warm_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      any_in  = any_ff;
      if (accept && (warm_ff < width_ff)) begin
         warm_in = warm_ff + WW'(1);
      end
      if (produce) begin
         any_in = any_ff | rem;
         priority if (last) begin
            warm_in = '0;
            row_in  = '0;
            col_in  = '0;
            any_in  = 1'b0;
         end else if (col_end) begin
            col_in = '0;
            row_in = row_ff + HW'(1);
         end else begin
            col_in = col_ff + WW'(1);
         end
      end
      if (restart) begin
         warm_in = '0;
         row_in  = '0;
         col_in  = '0;
         any_in  = 1'b0;
      end
   end

   // two-entry output buffer: head register plus skid
   always_comb begin
      pop           = out_valid_ff && rsp_ready;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      priority if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_valid_ff) begin
         if (pop && produce) begin
            out_in = result;
         end else if (pop) begin
            out_valid_in = 1'b0;
         end else if (produce) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else begin
         if (produce) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         algorithm_ff  <= 1'b0;
         subiter_ff    <= 1'b0;
         width_ff      <= WW'(W_RESET);
         height_ff     <= HW'(H_RESET);
         wp_ff         <= '0;
         fill_ff       <= '0;
         valid_a_ff    <= 1'b0;
         valid_b_ff    <= 1'b0;
         warm_ff       <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         any_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         algorithm_ff  <= algorithm_in;
         subiter_ff    <= subiter_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         wp_ff         <= wp_in;
         fill_ff       <= fill_in;
         valid_a_ff    <= valid_a_in;
         valid_b_ff    <= valid_b_in;
         warm_ff       <= warm_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         any_ff        <= any_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pixel_out     = out_ff.pixel_out;
   assign rsp_removed       = out_ff.removed;
   assign rsp_frame_last    = out_ff.frame_last;
   assign rsp_frame_changed = out_ff.frame_changed;

endmodule

// ===== rtl/core/btp_checker.sv =====
// Port-level checks for binary_thinning_pass_unit, attached by bind.
// Depends on the top level's port list.

module btp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_pixel_out,
   input logic rsp_removed,
   input logic rsp_frame_last,
   input logic rsp_frame_changed
);

   // a removed pixel always leaves as background
   a_removed_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_removed |-> !rsp_pixel_out)
      else $error("removed beat carries a foreground pixel");

   // the change flag only rides on the last beat of a frame
   a_changed_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_changed |-> rsp_frame_last)
      else $error("frame_changed set away from the frame's last beat");

   // with the output buffer empty, input is always taken
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while no result is held");

   // nothing is offered straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_out)
         && $stable(rsp_removed) && $stable(rsp_frame_last)
         && $stable(rsp_frame_changed))
      else $error("stalled result beat changed");

endmodule

bind binary_thinning_pass_unit btp_checker u_btp_checker (.*);
